// ===== rtl/pisf_pkg.sv =====
// ----------------------------------------------------------------------------
// pisf_pkg: shared types and constants of the pairwise force block
// Payload structs, the request entry passed from front to back, and widths.
// ----------------------------------------------------------------------------
package pisf_pkg;

   localparam int WORD_W      = 32;   // positions, amounts, couplings, forces
   localparam int MIN_W       = 31;   // minimum separation
   localparam int DIFF_W      = 33;   // magnitude of a position difference
   localparam int SQ_W        = 66;   // dx^2 + dy^2
   localparam int MIN_SQ_W    = 62;   // min_separation^2
   localparam int ROOT_W      = 34;   // rounded root, room for the round-up
   localparam int ROOT_STEPS  = 33;   // root bits resolved, one per stage
   localparam int KQQ_W       = 96;   // K * q1 * q2
   localparam int NUM_W       = 128;  // K * q1 * q2 * |d|
   localparam int DEN_W       = 102;  // r^3
   localparam int QUO_W       = 33;   // quotient bits, one per stage
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 2;

   localparam logic [WORD_W-1:0] COUPLING_RESET = 32'h0001_0000;
   localparam logic [MIN_W-1:0]  MIN_SEP_RESET  = 31'h0001_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRAVITY = 2'd0,
      CSR_COULOMB = 2'd1,
      CSR_MIN_SEP = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     mode;
      logic signed [WORD_W-1:0] first_x;
      logic signed [WORD_W-1:0] first_y;
      logic signed [WORD_W-1:0] second_x;
      logic signed [WORD_W-1:0] second_y;
      logic signed [WORD_W-1:0] first_amount;
      logic signed [WORD_W-1:0] second_amount;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] force_x;
      logic signed [WORD_W-1:0] force_y;
      logic                     too_close;
      logic                     saturated;
   } rsp_type;

   // classified request, front to back
   typedef struct packed {
      logic              too_close;
      logic              skip;       // zero force: too close or coincident
      logic              neg_x;
      logic              neg_y;
      logic [DIFF_W-1:0] adx;
      logic [DIFF_W-1:0] ady;
      logic [SQ_W-1:0]   s2;
      logic [WORD_W-1:0] kmag;
      logic [WORD_W-1:0] q1mag;
      logic [WORD_W-1:0] q2mag;
   } job_type;

endpackage

// ===== rtl/pisf_front.sv =====
// ----------------------------------------------------------------------------
// pisf_front: request intake and classification
// Forms offsets, magnitudes and signs, squares them and flags close pairs.
// ----------------------------------------------------------------------------
module pisf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pisf_pkg::req_type             req_data,
   input  logic [pisf_pkg::WORD_W-1:0]   gravity_coupling,
   input  logic [pisf_pkg::WORD_W-1:0]   coulomb_coupling,
   input  logic [pisf_pkg::MIN_W-1:0]    min_separation,
   output logic                          push_valid,
   output pisf_pkg::job_type             push_data,
   input  logic                          push_ok
);

   typedef struct packed {
      logic                            neg_x;
      logic                            neg_y;
      logic [pisf_pkg::WORD_W-1:0]     kmag;
      logic [pisf_pkg::WORD_W-1:0]     q1mag;
      logic [pisf_pkg::WORD_W-1:0]     q2mag;
   } carry_type;

   function automatic logic [pisf_pkg::WORD_W-1:0] mag_word(
      input logic [pisf_pkg::WORD_W-1:0] v);
      return v[pisf_pkg::WORD_W-1] ? (~v + 32'd1) : v;
   endfunction

   logic                              advance;
   logic [pisf_pkg::DIFF_W-1:0]       dx;
   logic [pisf_pkg::DIFF_W-1:0]       dy;
   logic [pisf_pkg::WORD_W-1:0]       k_sel;
   logic                              sgn;
   carry_type                         carry_in;
   logic [pisf_pkg::DIFF_W-1:0]       adx_in;
   logic [pisf_pkg::DIFF_W-1:0]       ady_in;

   logic                              f1_valid_ff;
   carry_type                         f1_carry_ff;
   logic [pisf_pkg::DIFF_W-1:0]       f1_adx_ff;
   logic [pisf_pkg::DIFF_W-1:0]       f1_ady_ff;
   logic [pisf_pkg::MIN_W-1:0]        f1_min_ff;

   logic                              f2_valid_ff;
   carry_type                         f2_carry_ff;
   logic [pisf_pkg::DIFF_W-1:0]       f2_adx_ff;
   logic [pisf_pkg::DIFF_W-1:0]       f2_ady_ff;
   logic [pisf_pkg::SQ_W-1:0]         sqx_in;
   logic [pisf_pkg::SQ_W-1:0]         sqy_in;
   logic [pisf_pkg::MIN_SQ_W-1:0]     min2_in;
   logic [pisf_pkg::SQ_W-1:0]         sqx_ff;
   logic [pisf_pkg::SQ_W-1:0]         sqy_ff;
   logic [pisf_pkg::MIN_SQ_W-1:0]     min2_ff;

   logic [pisf_pkg::SQ_W-1:0]         s2;
   logic                              close;

   // hold the whole front while the last stage cannot hand off
   assign advance   = !f2_valid_ff || push_ok;
   assign req_stall = !advance;

   always_comb begin
      dx = {req_data.second_x[pisf_pkg::WORD_W-1], req_data.second_x}
         - {req_data.first_x[pisf_pkg::WORD_W-1], req_data.first_x};
      dy = {req_data.second_y[pisf_pkg::WORD_W-1], req_data.second_y}
         - {req_data.first_y[pisf_pkg::WORD_W-1], req_data.first_y};
      adx_in = dx[pisf_pkg::DIFF_W-1] ? (~dx + 33'd1) : dx;
      ady_in = dy[pisf_pkg::DIFF_W-1] ? (~dy + 33'd1) : dy;
      k_sel  = req_data.mode ? coulomb_coupling : gravity_coupling;
      sgn    = k_sel[pisf_pkg::WORD_W-1] ^ req_data.first_amount[pisf_pkg::WORD_W-1]
             ^ req_data.second_amount[pisf_pkg::WORD_W-1];
      carry_in.neg_x = sgn ^ dx[pisf_pkg::DIFF_W-1];
      carry_in.neg_y = sgn ^ dy[pisf_pkg::DIFF_W-1];
      carry_in.kmag  = mag_word(k_sel);
      carry_in.q1mag = mag_word(req_data.first_amount);
      carry_in.q2mag = mag_word(req_data.second_amount);
   end

   always_comb begin
      sqx_in  = f1_adx_ff * f1_adx_ff;
      sqy_in  = f1_ady_ff * f1_ady_ff;
      min2_in = f1_min_ff * f1_min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_carry_ff <= carry_in;
         f1_adx_ff   <= adx_in;
         f1_ady_ff   <= ady_in;
         f1_min_ff   <= min_separation;
         f2_carry_ff <= f1_carry_ff;
         f2_adx_ff   <= f1_adx_ff;
         f2_ady_ff   <= f1_ady_ff;
         sqx_ff      <= sqx_in;
         sqy_ff      <= sqy_in;
         min2_ff     <= min2_in;
      end
   end

   always_comb begin
      s2    = sqx_ff + sqy_ff;
      close = s2 < {{(pisf_pkg::SQ_W - pisf_pkg::MIN_SQ_W){1'b0}}, min2_ff};
      push_valid           = f2_valid_ff;
      push_data.too_close  = close;
      push_data.skip       = close || (s2 == '0);
      push_data.neg_x      = f2_carry_ff.neg_x;
      push_data.neg_y      = f2_carry_ff.neg_y;
      push_data.adx        = f2_adx_ff;
      push_data.ady        = f2_ady_ff;
      push_data.s2         = s2;
      push_data.kmag       = f2_carry_ff.kmag;
      push_data.q1mag      = f2_carry_ff.q1mag;
      push_data.q2mag      = f2_carry_ff.q2mag;
   end

endmodule

// ===== rtl/pisf_queue.sv =====
// ----------------------------------------------------------------------------
// pisf_queue: short request queue between front and back
// Lets the front keep taking requests while the back is held by the output.
// ----------------------------------------------------------------------------
module pisf_queue #(
   parameter int DEPTH = pisf_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  pisf_pkg::job_type   push_data,
   output logic                push_ok,
   output logic                head_valid,
   output pisf_pkg::job_type   head_data,
   input  logic                pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pisf_pkg::job_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;

   assign push_ok    = (count_ff != CNT_W'(DEPTH)) || pop;
   assign push       = push_valid && push_ok;
   assign head_valid = count_ff != '0;
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !pop) |=> (head_valid && $stable(head_data)))
      else $error("queue head changed before it was popped");

endmodule

// ===== rtl/pisf_back.sv =====
// ----------------------------------------------------------------------------
// pisf_back: force datapath
// Numerator product, pipelined rounded root, r^3, pipelined divide, saturate.
// ----------------------------------------------------------------------------
module pisf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  pisf_pkg::job_type   job_data,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pisf_pkg::rsp_type   rsp_data
);

   localparam int DIV_W = pisf_pkg::DEN_W + pisf_pkg::QUO_W;
   localparam int SQ_X  = pisf_pkg::SQ_W + 2;

   typedef struct packed {
      logic too_close;
      logic skip;
      logic neg_x;
      logic neg_y;
   } meta_type;

   typedef struct packed {
      meta_type                      meta;
      logic [pisf_pkg::SQ_W-1:0]     rem;
      logic [pisf_pkg::ROOT_W-1:0]   root;
      logic [pisf_pkg::NUM_W-1:0]    num_x;
      logic [pisf_pkg::NUM_W-1:0]    num_y;
   } root_stage_type;

   typedef struct packed {
      meta_type                      meta;
      logic                          sat_x;
      logic                          sat_y;
      logic [pisf_pkg::DEN_W-1:0]    den;
      logic [pisf_pkg::NUM_W-1:0]    rem_x;
      logic [pisf_pkg::NUM_W-1:0]    rem_y;
      logic [pisf_pkg::QUO_W-1:0]    quo_x;
      logic [pisf_pkg::QUO_W-1:0]    quo_y;
   } div_stage_type;

   logic                              en;

   // numerator stages
   logic                              b0_valid_ff, b1_valid_ff, b2_valid_ff, b3_valid_ff;
   pisf_pkg::job_type                 b0_job_ff, b1_job_ff, b2_job_ff, b3_job_ff;
   logic [63:0]                       b0_kq1_ff;
   logic [63:0]                       b1_lo_ff, b1_hi_ff;
   logic [pisf_pkg::KQQ_W-1:0]        b2_kqq_ff;
   logic [64:0]                       b3_px_ff [3];
   logic [64:0]                       b3_py_ff [3];
   root_stage_type                    root_in;

   // root stages
   root_stage_type                    rt_ff [pisf_pkg::ROOT_STEPS+1];
   logic [pisf_pkg::ROOT_STEPS:0]     rt_valid_ff;

   // round and cube stages
   logic                              rd_valid_ff, c1_valid_ff, c2_valid_ff, c3_valid_ff;
   meta_type                          rd_meta_ff, c1_meta_ff, c2_meta_ff, c3_meta_ff;
   logic [pisf_pkg::NUM_W-1:0]        rd_nx_ff, rd_ny_ff, c1_nx_ff, c1_ny_ff;
   logic [pisf_pkg::NUM_W-1:0]        c2_nx_ff, c2_ny_ff, c3_nx_ff, c3_ny_ff;
   logic [pisf_pkg::ROOT_W-1:0]       rd_root_in, rd_root_ff, c1_root_ff;
   logic [2*pisf_pkg::ROOT_W-1:0]     c1_r2_ff;
   logic [2*pisf_pkg::ROOT_W-1:0]     c2_lo_ff, c2_hi_ff;
   logic [pisf_pkg::DEN_W-1:0]        c3_den_ff;

   // divide stages
   div_stage_type                     div_in;
   div_stage_type                     dv_ff [pisf_pkg::QUO_W+1];
   logic [pisf_pkg::QUO_W:0]          dv_valid_ff;

   // output
   logic [pisf_pkg::QUO_W-1:0]        limit_x, limit_y, mag_x, mag_y, signed_x, signed_y;
   logic                              clip_x, clip_y;
   div_stage_type                     last;
   pisf_pkg::rsp_type                 rsp_in;
   pisf_pkg::rsp_type                 rsp_ff;
   logic                              rsp_valid_ff;

   // the whole pipe holds while a finished result waits
   assign en      = !(rsp_valid_ff && rsp_stall);
   assign job_pop = en && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else if (en) begin
         b0_valid_ff <= job_valid;
         b1_valid_ff <= b0_valid_ff;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0_job_ff <= job_data;
         b0_kq1_ff <= job_data.kmag * job_data.q1mag;
         b1_job_ff <= b0_job_ff;
         b1_lo_ff  <= b0_kq1_ff[31:0]  * b0_job_ff.q2mag;
         b1_hi_ff  <= b0_kq1_ff[63:32] * b0_job_ff.q2mag;
         b2_job_ff <= b1_job_ff;
         b2_kqq_ff <= pisf_pkg::KQQ_W'(b1_lo_ff)
                    + (pisf_pkg::KQQ_W'(b1_hi_ff) << 32);
         b3_job_ff <= b2_job_ff;
         for (int j = 0; j < 3; j++) begin
            b3_px_ff[j] <= b2_kqq_ff[32*j +: 32] * b2_job_ff.adx;
            b3_py_ff[j] <= b2_kqq_ff[32*j +: 32] * b2_job_ff.ady;
         end
      end
   end

   always_comb begin
      root_in.meta.too_close = b3_job_ff.too_close;
      root_in.meta.skip      = b3_job_ff.skip;
      root_in.meta.neg_x     = b3_job_ff.neg_x;
      root_in.meta.neg_y     = b3_job_ff.neg_y;
      root_in.rem            = b3_job_ff.s2;
      root_in.root           = '0;
      root_in.num_x = pisf_pkg::NUM_W'(b3_px_ff[0])
                    + (pisf_pkg::NUM_W'(b3_px_ff[1]) << 32)
                    + (pisf_pkg::NUM_W'(b3_px_ff[2]) << 64);
      root_in.num_y = pisf_pkg::NUM_W'(b3_py_ff[0])
                    + (pisf_pkg::NUM_W'(b3_py_ff[1]) << 32)
                    + (pisf_pkg::NUM_W'(b3_py_ff[2]) << 64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else if (en) begin
         rt_valid_ff[0] <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff[0] <= root_in;
      end
   end

   // one root bit per stage, remainder kept as s2 - root^2
   for (genvar j = 1; j <= pisf_pkg::ROOT_STEPS; j++) begin : g_root
      localparam int B = pisf_pkg::ROOT_STEPS - j;
      logic [SQ_X-1:0]  trial;
      logic             fits;
      root_stage_type   nxt;

      always_comb begin
         trial = (SQ_X'(rt_ff[j-1].root) << (B + 1)) + (SQ_X'(1) << (2 * B));
         fits  = SQ_X'(rt_ff[j-1].rem) >= trial;
         nxt   = rt_ff[j-1];
         if (fits) begin
            nxt.rem  = pisf_pkg::SQ_W'(SQ_X'(rt_ff[j-1].rem) - trial);
            nxt.root = rt_ff[j-1].root | (pisf_pkg::ROOT_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[j] <= 1'b0;
         end else if (en) begin
            rt_valid_ff[j] <= rt_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rt_ff[j] <= nxt;
         end
      end
   end

   // round to nearest: bump when the remainder exceeds the root
   always_comb begin
      rd_root_in = rt_ff[pisf_pkg::ROOT_STEPS].root;
      if (rt_ff[pisf_pkg::ROOT_STEPS].rem
          > pisf_pkg::SQ_W'(rt_ff[pisf_pkg::ROOT_STEPS].root)) begin
         rd_root_in = rt_ff[pisf_pkg::ROOT_STEPS].root + pisf_pkg::ROOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
         c3_valid_ff <= 1'b0;
      end else if (en) begin
         rd_valid_ff <= rt_valid_ff[pisf_pkg::ROOT_STEPS];
         c1_valid_ff <= rd_valid_ff;
         c2_valid_ff <= c1_valid_ff;
         c3_valid_ff <= c2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rd_meta_ff <= rt_ff[pisf_pkg::ROOT_STEPS].meta;
         rd_nx_ff   <= rt_ff[pisf_pkg::ROOT_STEPS].num_x;
         rd_ny_ff   <= rt_ff[pisf_pkg::ROOT_STEPS].num_y;
         rd_root_ff <= rd_root_in;
         c1_meta_ff <= rd_meta_ff;
         c1_nx_ff   <= rd_nx_ff;
         c1_ny_ff   <= rd_ny_ff;
         c1_root_ff <= rd_root_ff;
         c1_r2_ff   <= rd_root_ff * rd_root_ff;
         c2_meta_ff <= c1_meta_ff;
         c2_nx_ff   <= c1_nx_ff;
         c2_ny_ff   <= c1_ny_ff;
         c2_lo_ff   <= c1_r2_ff[pisf_pkg::ROOT_W-1:0] * c1_root_ff;
         c2_hi_ff   <= c1_r2_ff[2*pisf_pkg::ROOT_W-1:pisf_pkg::ROOT_W] * c1_root_ff;
         c3_meta_ff <= c2_meta_ff;
         c3_nx_ff   <= c2_nx_ff;
         c3_ny_ff   <= c2_ny_ff;
         c3_den_ff  <= pisf_pkg::DEN_W'(c2_lo_ff)
                     + (pisf_pkg::DEN_W'(c2_hi_ff) << pisf_pkg::ROOT_W);
      end
   end

   // quotient of 2^33 or more clips straight away
   always_comb begin
      div_in.meta  = c3_meta_ff;
      div_in.den   = c3_den_ff;
      div_in.rem_x = c3_nx_ff;
      div_in.rem_y = c3_ny_ff;
      div_in.quo_x = '0;
      div_in.quo_y = '0;
      div_in.sat_x = DIV_W'(c3_nx_ff) >= (DIV_W'(c3_den_ff) << pisf_pkg::QUO_W);
      div_in.sat_y = DIV_W'(c3_ny_ff) >= (DIV_W'(c3_den_ff) << pisf_pkg::QUO_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= c3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0] <= div_in;
      end
   end

   // restoring divide, one quotient bit per stage for both components
   for (genvar j = 1; j <= pisf_pkg::QUO_W; j++) begin : g_div
      localparam int I = pisf_pkg::QUO_W - j;
      logic [DIV_W-1:0]  dshift;
      logic              fits_x, fits_y;
      div_stage_type     nxt;

      always_comb begin
         dshift = DIV_W'(dv_ff[j-1].den) << I;
         fits_x = DIV_W'(dv_ff[j-1].rem_x) >= dshift;
         fits_y = DIV_W'(dv_ff[j-1].rem_y) >= dshift;
         nxt    = dv_ff[j-1];
         if (fits_x) begin
            nxt.rem_x = pisf_pkg::NUM_W'(DIV_W'(dv_ff[j-1].rem_x) - dshift);
            nxt.quo_x = dv_ff[j-1].quo_x | (pisf_pkg::QUO_W'(1) << I);
         end
         if (fits_y) begin
            nxt.rem_y = pisf_pkg::NUM_W'(DIV_W'(dv_ff[j-1].rem_y) - dshift);
            nxt.quo_y = dv_ff[j-1].quo_y | (pisf_pkg::QUO_W'(1) << I);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j] <= nxt;
         end
      end
   end

   // clip to the signed range, apply sign, zero the skipped pairs
   always_comb begin
      last     = dv_ff[pisf_pkg::QUO_W];
      limit_x  = last.meta.neg_x ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      limit_y  = last.meta.neg_y ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
      clip_x   = last.sat_x || (last.quo_x > limit_x);
      clip_y   = last.sat_y || (last.quo_y > limit_y);
      mag_x    = clip_x ? limit_x : last.quo_x;
      mag_y    = clip_y ? limit_y : last.quo_y;
      signed_x = last.meta.neg_x ? (~mag_x + 33'd1) : mag_x;
      signed_y = last.meta.neg_y ? (~mag_y + 33'd1) : mag_y;
      rsp_in.too_close = last.meta.too_close;
      if (last.meta.skip) begin
         rsp_in.force_x   = '0;
         rsp_in.force_y   = '0;
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.force_x   = signed_x[pisf_pkg::WORD_W-1:0];
         rsp_in.force_y   = signed_y[pisf_pkg::WORD_W-1:0];
         rsp_in.saturated = clip_x || clip_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[pisf_pkg::QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_close_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.too_close)
         |-> (rsp_ff.force_x == '0 && rsp_ff.force_y == '0 && !rsp_ff.saturated))
      else $error("close pair produced a force");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.saturated)
         |-> (rsp_ff.force_x == 32'sh7FFF_FFFF || rsp_ff.force_x == 32'sh8000_0000
              || rsp_ff.force_y == 32'sh7FFF_FFFF || rsp_ff.force_y == 32'sh8000_0000))
      else $error("saturated flag without a clipped component");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result changed");

endmodule

// ===== rtl/pairwise_inverse_square_force_top.sv =====
// ----------------------------------------------------------------------------
// pairwise_inverse_square_force_top: pairwise inverse-square force
// Force on the first body of a pair, gravity or Coulomb, signed Q16.16.
//
//   channel  ports        dir  moves
//   request  req_*        in   one body pair and mode per request
//   result   rsp_*        out  force_x, force_y, too_close, saturated
//   config   csr_*        in   couplings and minimum separation, write only
//
// One request per cycle sustained when nothing stalls; the root and divide
// pipelines resolve one result bit per stage each.
// Reset is synchronous and clears the pipe, the queue and the registers.
// A stalled result holds the back pipe; the four-entry queue lets the front
// keep taking requests until it fills.
// ----------------------------------------------------------------------------
module pairwise_inverse_square_force_top #(
   parameter int QUEUE_DEPTH = pisf_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  pisf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output pisf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write,
   input  logic [pisf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pisf_pkg::WORD_W-1:0]          csr_data
);

   logic [pisf_pkg::WORD_W-1:0]   grav_ff, grav_in;
   logic [pisf_pkg::WORD_W-1:0]   coul_ff, coul_in;
   logic [pisf_pkg::MIN_W-1:0]    min_sep_ff, min_sep_in;

   logic                          push_valid;
   pisf_pkg::job_type             push_data;
   logic                          push_ok;
   logic                          head_valid;
   pisf_pkg::job_type             head_data;
   logic                          pop;

   always_comb begin
      grav_in    = grav_ff;
      coul_in    = coul_ff;
      min_sep_in = min_sep_ff;
      if (csr_write) begin
         case (csr_index)
            pisf_pkg::CSR_GRAVITY: grav_in    = csr_data;
            pisf_pkg::CSR_COULOMB: coul_in    = csr_data;
            pisf_pkg::CSR_MIN_SEP: min_sep_in = csr_data[pisf_pkg::MIN_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff    <= pisf_pkg::COUPLING_RESET;
         coul_ff    <= pisf_pkg::COUPLING_RESET;
         min_sep_ff <= pisf_pkg::MIN_SEP_RESET;
      end else begin
         grav_ff    <= grav_in;
         coul_ff    <= coul_in;
         min_sep_ff <= min_sep_in;
      end
   end

   pisf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .gravity_coupling (grav_ff),
      .coulomb_coupling (coul_ff),
      .min_separation   (min_sep_ff),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .push_ok          (push_ok)
   );

   pisf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ok    (push_ok),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   pisf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job_data  (head_data),
      .job_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
